>>> rtl/mcab_pkg.sv
// Shared constants for the interleaved channel boxcar averager.
// Used by the averager top level and its divider.
`timescale 1ns / 1ps

package mcab_pkg;

   // Fixed widths of the request and response fields.
   localparam int SAMPLE_W = 10;
   localparam int CHAN_W   = 3;
   // An average never exceeds the largest sample, so the quotient is this wide.
   localparam int QUO_W    = SAMPLE_W;

   localparam int DEF_NUM_CHANNELS = 5;
   localparam int DEF_WINDOW_LEN   = 16;

   // An average is produced whenever the low slot bits under this mask are zero.
   localparam logic [1:0] PHASE_MASK = 2'b11;

endpackage

>>> rtl/mcab_div.sv
// Divides a window sum by the constant window length with a scaled reciprocal.
// The quotient is registered and ready, with done, in the cycle after start; depends on mcab_pkg.
`timescale 1ns / 1ps

module mcab_div #(
   parameter int WINDOW_LEN = mcab_pkg::DEF_WINDOW_LEN,
   parameter int SUM_W      = mcab_pkg::SAMPLE_W + $clog2(mcab_pkg::DEF_WINDOW_LEN)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [SUM_W-1:0]            dividend,
   output logic                        done,
   output logic [mcab_pkg::QUO_W-1:0]  quotient
);
   import mcab_pkg::*;

   // The reciprocal is rounded up and scaled by 2**SHIFT, which keeps the
   // truncated product exact for every dividend below 2**SUM_W.
   localparam int SHIFT   = SUM_W + $clog2(WINDOW_LEN);
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

   logic [PROD_W-1:0] prod;
   logic [QUO_W-1:0]  quo_ff;
   logic              done_ff;

   assign prod     = {{RECIP_W{1'b0}}, dividend} * {{SUM_W{1'b0}}, RECIP};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
         if (start) begin
            quo_ff <= prod[SHIFT +: QUO_W];
         end
      end
   end

endmodule

>>> rtl/multichannel_adc_boxcar_average.sv
// Channel  | Direction | Ports
// request  | in        | req_valid, req_ready, req_sample[9:0]
// response | out       | rsp_valid, rsp_ready, rsp_avg_channel[2:0], rsp_average[9:0]
//
// A request that yields no response leaves the block in ST_IDLE, ready for the next one. One
// that yields a response holds the input off while the block reads each stored sample of
// that channel through the single memory read port, finishes the sum, runs the reciprocal
// divide and loads the response. After reset the memory is zeroed one entry per cycle, all
// NUM_CHANNELS * WINDOW_LEN entries (80 at the default), before the first request. A second
// response waits, stalling requests, until the pending one is taken.
`timescale 1ns / 1ps

module multichannel_adc_boxcar_average #(
   parameter int NUM_CHANNELS = mcab_pkg::DEF_NUM_CHANNELS,
   parameter int WINDOW_LEN   = mcab_pkg::DEF_WINDOW_LEN
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mcab_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mcab_pkg::CHAN_W-1:0]    rsp_avg_channel,
   output logic [mcab_pkg::QUO_W-1:0]     rsp_average
);
   import mcab_pkg::*;

   localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int SLOT_W = $clog2(WINDOW_LEN);
   localparam int DEPTH  = NUM_CHANNELS * WINDOW_LEN;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_LAST, ST_DIV, ST_OUT
   } state_type;

   state_type         state_ff;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] idx_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [CH_W-1:0]   avg_ch_ff;
   logic [SUM_W-1:0]  acc_ff;
   logic              rd_vld_ff;
   logic              div_start_ff;
   logic              rsp_valid_ff;
   logic [CHAN_W-1:0] rsp_ch_ff;
   logic [QUO_W-1:0]  rsp_avg_ff;

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [SAMPLE_W-1:0] wr_data;
   logic                wr_en;

   logic              accept, emit;
   logic [SLOT_W+1:0] slot_ext;
   logic              div_done;
   logic [QUO_W-1:0]  div_quo;

   assign req_ready       = (state_ff == ST_IDLE);
   assign accept          = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_avg_channel = rsp_ch_ff;
   assign rsp_average     = rsp_avg_ff;

   // Pointer advance: the slot moves only when the channel wraps.
   always_comb begin
      ch_in   = ch_ff;
      slot_in = slot_ff;
      if (ch_ff == CH_W'(NUM_CHANNELS - 1)) begin
         ch_in = '0;
         if (slot_ff == SLOT_W'(WINDOW_LEN - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end else begin
         ch_in = ch_ff + CH_W'(1);
      end
   end

   assign slot_ext = {2'b00, slot_in};
   assign emit     = ((slot_ext[1:0] & PHASE_MASK) == 2'b00);

   assign wr_en   = (state_ff == ST_CLEAR) || accept;
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff
                  : ADDR_W'(32'(ch_ff) * WINDOW_LEN) + ADDR_W'(slot_ff);
   assign wr_data = (state_ff == ST_CLEAR) ? '0 : req_sample;
   assign rd_addr = base_ff + ADDR_W'(idx_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   mcab_div #(
      .WINDOW_LEN (WINDOW_LEN),
      .SUM_W      (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (acc_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ch_ff        <= '0;
         slot_ff      <= '0;
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= (state_ff == ST_LAST);
         rd_vld_ff    <= (state_ff == ST_READ);
         // In ST_OUT the response register is either reloaded or left alone.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         // The read data is registered, so it arrives in the cycle after its address.
         if (rd_vld_ff) begin
            acc_ff <= acc_ff + SUM_W'(rd_data_ff);
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + ADDR_W'(1);
               if (clr_ff == ADDR_W'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  ch_ff   <= ch_in;
                  slot_ff <= slot_in;
                  if (emit) begin
                     avg_ch_ff <= ch_in;
                     base_ff   <= ADDR_W'(32'(ch_in) * WINDOW_LEN);
                     idx_ff    <= '0;
                     acc_ff    <= '0;
                     state_ff  <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               idx_ff <= idx_ff + SLOT_W'(1);
               if (idx_ff == SLOT_W'(WINDOW_LEN - 1)) begin
                  state_ff <= ST_LAST;
               end
            end
            ST_LAST: begin
               // The final sample is added on this edge; the sum is complete next.
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ch_ff    <= CHAN_W'(avg_ch_ff);
                  rsp_avg_ff   <= div_quo;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

>>> dv/multichannel_adc_boxcar_average_test.sv
// Self-checking testbench for the interleaved five-channel boxcar averager.
// Depends on rtl/mcab_pkg.sv and rtl/multichannel_adc_boxcar_average.sv.
`timescale 1ns / 1ps

module multichannel_adc_boxcar_average_test;
   import mcab_pkg::*;

   localparam int NUM_CH       = DEF_NUM_CHANNELS;
   localparam int WIN_LEN      = DEF_WINDOW_LEN;
   localparam int DIRECTED_N   = 24;
   localparam int RANDOM_N     = 1876;
   localparam int QUIET_TAIL   = 200;   // last requests run without any idling
   localparam int HOLD_AT      = 500;   // random request index that starts the long hold
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 64;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic [QUO_W-1:0]  avg;
   } avg_rsp_type;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      bit                  typed;   // expected response typed in the table
      avg_rsp_type         want;
   } sample_req_type;

   localparam avg_rsp_type UNTYPED = '0;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [CHAN_W-1:0]   rsp_avg_channel;
   logic [QUO_W-1:0]    rsp_average;

   multichannel_adc_boxcar_average dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_avg_channel (rsp_avg_channel),
      .rsp_average     (rsp_average)
   );

   always #10 clock = ~clock;

   // Predictor state: the window memory and the two pointers.
   logic [SAMPLE_W-1:0] window_mem [NUM_CH][WIN_LEN];
   int                  next_chan = 0;
   int                  next_slot = 0;

   sample_req_type pending_samples [$];
   avg_rsp_type    awaited_averages [$];

   int  errors        = 0;
   int  samples_taken = 0;
   int  averages_seen = 0;
   int  input_stalls  = 0;
   bit  idling        = 1'b1;
   bit  hold_asked    = 1'b0;

   // Directed requests: extremes and alternating bit patterns. Channel 0 gets a
   // full-scale sample in the first four slots, so its first average is 4092 / 16.
   sample_req_type directed_rows [DIRECTED_N] = '{
      '{10'h3FF, 1'b1, '{3'd1, 10'd0}},
      '{10'h000, 1'b1, '{3'd2, 10'd0}},
      '{10'h2AA, 1'b1, '{3'd3, 10'd0}},
      '{10'h155, 1'b1, '{3'd4, 10'd0}},
      '{10'h001, 1'b0, UNTYPED},
      '{10'h3FF, 1'b0, UNTYPED},
      '{10'h200, 1'b0, UNTYPED},
      '{10'h1FF, 1'b0, UNTYPED},
      '{10'h3FE, 1'b0, UNTYPED},
      '{10'h001, 1'b0, UNTYPED},
      '{10'h3FF, 1'b0, UNTYPED},
      '{10'h155, 1'b0, UNTYPED},
      '{10'h2AA, 1'b0, UNTYPED},
      '{10'h000, 1'b0, UNTYPED},
      '{10'h3FF, 1'b0, UNTYPED},
      '{10'h3FF, 1'b0, UNTYPED},
      '{10'h0F0, 1'b0, UNTYPED},
      '{10'h30F, 1'b0, UNTYPED},
      '{10'h080, 1'b0, UNTYPED},
      '{10'h3FF, 1'b1, '{3'd0, 10'd255}},
      '{10'h123, 1'b0, UNTYPED},
      '{10'h3FF, 1'b0, UNTYPED},
      '{10'h000, 1'b0, UNTYPED},
      '{10'h2AA, 1'b0, UNTYPED}
   };

   initial begin
      for (int c = 0; c < NUM_CH; c++)
         for (int k = 0; k < WIN_LEN; k++)
            window_mem[c][k] = '0;
   end

   // Stores one sample and returns 1 when the next channel's average is due.
   function automatic bit window_average_step(input logic [SAMPLE_W-1:0] s,
                                              output avg_rsp_type res);
      int unsigned acc = 0;
      logic [3:0]  slot_bits;
      window_mem[next_chan][next_slot] = s;
      if (next_chan == NUM_CH - 1) begin
         next_chan = 0;
         next_slot = (next_slot == WIN_LEN - 1) ? 0 : next_slot + 1;
      end else begin
         next_chan = next_chan + 1;
      end
      slot_bits = next_slot[3:0];
      res = UNTYPED;
      if ((slot_bits[1:0] & PHASE_MASK) != '0)
         return 1'b0;
      for (int k = 0; k < WIN_LEN; k++)
         acc += window_mem[next_chan][k];
      res.chan = next_chan[CHAN_W-1:0];
      res.avg  = QUO_W'(acc / WIN_LEN);
      return 1'b1;
   endfunction

   task automatic note_error(input string what, input avg_rsp_type want,
                             input avg_rsp_type got);
      errors++;
      if (errors <= REPORT_MAX)
         $display("%0t ns: %s: expected channel %0d average %0d, got channel %0d average %0d",
                  $time, what, want.chan, want.avg, got.chan, got.avg);
   endtask

   // Both handshakes are observed here, on the values seen at the clock edge.
   always @(posedge clock) begin : watch
      sample_req_type r;
      avg_rsp_type    pred;
      avg_rsp_type    got;
      avg_rsp_type    want;
      bit             due;
      if (!reset) begin
         if (req_valid && !req_ready)
            input_stalls++;
         if (req_valid && req_ready) begin
            r = pending_samples.pop_front();
            due = window_average_step(r.sample, pred);
            if (r.typed)
               awaited_averages.push_back(r.want);
            else if (due)
               awaited_averages.push_back(pred);
            samples_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            got.chan = rsp_avg_channel;
            got.avg  = rsp_average;
            averages_seen++;
            if (awaited_averages.size() == 0) begin
               note_error("unexpected response", UNTYPED, got);
            end else begin
               want = awaited_averages.pop_front();
               if (got.chan != want.chan)
                  note_error("wrong channel", want, got);
               else if (got.avg != want.avg)
                  note_error("wrong average", want, got);
            end
         end
      end
   end

   task automatic send_sample(input sample_req_type r);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      pending_samples.push_back(r);
      req_valid  <= 1'b1;
      req_sample <= r.sample;
      do @(posedge clock); while (!req_ready);
   endtask

   // Response side: random stall bursts, plus one long hold that backs the block up.
   initial begin : receiver
      while (reset) @(posedge clock);
      forever begin
         if (hold_asked) begin
            hold_asked = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idling && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      sample_req_type r;
      int             level [NUM_CH];
      int             v;
      int             mode;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_N; i++)
         send_sample(directed_rows[i]);

      for (int c = 0; c < NUM_CH; c++)
         level[c] = $urandom_range(0, 1023);
      for (int i = 0; i < RANDOM_N; i++) begin
         if (i == HOLD_AT)
            hold_asked = 1'b1;
         if (i == RANDOM_N - QUIET_TAIL)
            idling = 1'b0;
         if ($urandom_range(0, 99) == 0)
            level[$urandom_range(0, NUM_CH - 1)] = $urandom_range(0, 1023);
         mode = $urandom_range(0, 9);
         if (mode < 4) begin
            v = $urandom_range(0, 1023);
         end else if (mode < 6) begin
            v = $urandom_range(0, 1) ? 1023 : 0;
         end else begin
            // Slowly varying level per channel, like a real converter input.
            v = level[(DIRECTED_N + i) % NUM_CH] + $urandom_range(0, 64) - 32;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
         end
         r.sample = v[SAMPLE_W-1:0];
         r.typed  = 1'b0;
         r.want   = UNTYPED;
         send_sample(r);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (awaited_averages.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_averages.size() != 0)
         errors += awaited_averages.size();

      $display("Run covered %0d samples (%0d directed) and %0d checked averages.",
               samples_taken, DIRECTED_N, averages_seen);
      $display("Request side was held off for %0d cycles; %0d errors found.",
               input_stalls, errors);
      if (errors == 0)
         $display("multichannel_adc_boxcar_average_test: PASS");
      else
         $display("multichannel_adc_boxcar_average_test: FAIL");
      $finish;
   end

   initial begin : watchdog
      #12_000_000;
      $display("Run stopped by the watchdog.");
      $display("multichannel_adc_boxcar_average_test: FAIL");
      $finish;
   end

endmodule

>>> filelist.f
rtl/mcab_pkg.sv
rtl/mcab_div.sv
rtl/multichannel_adc_boxcar_average.sv
dv/multichannel_adc_boxcar_average_test.sv
